// File: src/rtnh_pkg.sv
// shared types, constants and the dot/cross product term schedule for the ray-triangle core
package rtnh_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;

   localparam int DIST_W = 31;
   localparam int THR_W = 63;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 63;
   localparam int DIG_W = 8;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
   localparam logic [THR_W-1:0] DET_THR_RESET = 63'd281474977;

   typedef enum logic [CSR_AW-1:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_ORIGIN_Z = 3'd2,
      CSR_DIR_X = 3'd3,
      CSR_DIR_Y = 3'd4,
      CSR_DIR_Z = 3'd5,
      CSR_DET_THR = 3'd6,
      CSR_MIN_DIST = 3'd7
   } csr_idx_type;

   // operand codes: narrow vectors first, then cross product results
   typedef enum logic [4:0] {
      OP_D0, OP_D1, OP_D2,
      OP_E1_0, OP_E1_1, OP_E1_2,
      OP_E2_0, OP_E2_1, OP_E2_2,
      OP_S0, OP_S1, OP_S2,
      OP_H0, OP_H1, OP_H2,
      OP_Q0, OP_Q1, OP_Q2
   } opnd_type;

   typedef enum logic [3:0] {
      DST_H0, DST_H1, DST_H2,
      DST_Q0, DST_Q1, DST_Q2,
      DST_DET, DST_UN, DST_VN, DST_TN
   } dst_type;

   typedef struct packed {
      opnd_type a_src;
      opnd_type b_src;
      logic neg;
      logic first;
      logic last;
      dst_type dst;
   } term_type;

   typedef struct packed {
      logic start;
      logic first;
      logic neg;
   } mac_ctl_type;

   localparam int NUM_TERMS = 24;
   localparam int TERM_IDX_W = 5;

   function automatic term_type mk(input opnd_type a, input opnd_type b, input logic n,
                                   input logic f, input logic l, input dst_type d);
      term_type t;
      t.a_src = a;
      t.b_src = b;
      t.neg = n;
      t.first = f;
      t.last = l;
      t.dst = d;
      return t;
   endfunction

   // h = d x e2, det = h.e1, un = h.s, q = s x e1, vn = q.d, tn = q.e2
   function automatic term_type get_term(input logic [TERM_IDX_W-1:0] idx);
      term_type t;
      unique case (idx)
         5'd0: t = mk(OP_D1, OP_E2_2, 1'b0, 1'b1, 1'b0, DST_H0);
         5'd1: t = mk(OP_D2, OP_E2_1, 1'b1, 1'b0, 1'b1, DST_H0);
         5'd2: t = mk(OP_D2, OP_E2_0, 1'b0, 1'b1, 1'b0, DST_H1);
         5'd3: t = mk(OP_D0, OP_E2_2, 1'b1, 1'b0, 1'b1, DST_H1);
         5'd4: t = mk(OP_D0, OP_E2_1, 1'b0, 1'b1, 1'b0, DST_H2);
         5'd5: t = mk(OP_D1, OP_E2_0, 1'b1, 1'b0, 1'b1, DST_H2);
         5'd6: t = mk(OP_H0, OP_E1_0, 1'b0, 1'b1, 1'b0, DST_DET);
         5'd7: t = mk(OP_H1, OP_E1_1, 1'b0, 1'b0, 1'b0, DST_DET);
         5'd8: t = mk(OP_H2, OP_E1_2, 1'b0, 1'b0, 1'b1, DST_DET);
         5'd9: t = mk(OP_H0, OP_S0, 1'b0, 1'b1, 1'b0, DST_UN);
         5'd10: t = mk(OP_H1, OP_S1, 1'b0, 1'b0, 1'b0, DST_UN);
         5'd11: t = mk(OP_H2, OP_S2, 1'b0, 1'b0, 1'b1, DST_UN);
         5'd12: t = mk(OP_S1, OP_E1_2, 1'b0, 1'b1, 1'b0, DST_Q0);
         5'd13: t = mk(OP_S2, OP_E1_1, 1'b1, 1'b0, 1'b1, DST_Q0);
         5'd14: t = mk(OP_S2, OP_E1_0, 1'b0, 1'b1, 1'b0, DST_Q1);
         5'd15: t = mk(OP_S0, OP_E1_2, 1'b1, 1'b0, 1'b1, DST_Q1);
         5'd16: t = mk(OP_S0, OP_E1_1, 1'b0, 1'b1, 1'b0, DST_Q2);
         5'd17: t = mk(OP_S1, OP_E1_0, 1'b1, 1'b0, 1'b1, DST_Q2);
         5'd18: t = mk(OP_Q0, OP_D0, 1'b0, 1'b1, 1'b0, DST_VN);
         5'd19: t = mk(OP_Q1, OP_D1, 1'b0, 1'b0, 1'b0, DST_VN);
         5'd20: t = mk(OP_Q2, OP_D2, 1'b0, 1'b0, 1'b1, DST_VN);
         5'd21: t = mk(OP_Q0, OP_E2_0, 1'b0, 1'b1, 1'b0, DST_TN);
         5'd22: t = mk(OP_Q1, OP_E2_1, 1'b0, 1'b0, 1'b0, DST_TN);
         5'd23: t = mk(OP_Q2, OP_E2_2, 1'b0, 1'b0, 1'b1, DST_TN);
         default: t = mk(OP_D0, OP_D0, 1'b0, 1'b1, 1'b1, DST_TN);
      endcase
      return t;
   endfunction

endpackage

// File: src/rtnh_req_if.sv
// triangle input channel
interface rtnh_req_if import rtnh_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
   logic valid;
   logic ready;
   logic signed [COORD_WIDTH-1:0] a_x;
   logic signed [COORD_WIDTH-1:0] a_y;
   logic signed [COORD_WIDTH-1:0] a_z;
   logic signed [COORD_WIDTH-1:0] b_x;
   logic signed [COORD_WIDTH-1:0] b_y;
   logic signed [COORD_WIDTH-1:0] b_z;
   logic signed [COORD_WIDTH-1:0] c_x;
   logic signed [COORD_WIDTH-1:0] c_y;
   logic signed [COORD_WIDTH-1:0] c_z;
   logic last_triangle;

   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                   last_triangle, input ready);
   modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                 last_triangle, output ready);
endinterface

// File: src/rtnh_rsp_if.sv
// hit result channel
interface rtnh_rsp_if import rtnh_pkg::*;;
   logic valid;
   logic ready;
   logic hit;
   logic [DIST_W-1:0] distance;

   modport source (output valid, hit, distance, input ready);
   modport sink (input valid, hit, distance, output ready);
endinterface

// File: src/rtnh_mac.sv
// shared multiply-accumulate unit, one 8-bit digit of the narrow operand per cycle
module rtnh_mac import rtnh_pkg::*; #(
   parameter int ACC_W = 102,
   parameter int B_W = 33
) (
   input  logic clock,
   input  logic reset,
   input  mac_ctl_type ctl,
   input  logic [ACC_W-1:0] a_op,
   input  logic signed [B_W-1:0] b_op,
   output logic [ACC_W-1:0] acc,
   output logic busy,
   output logic done
);
   localparam int NDIG = (B_W + DIG_W - 1) / DIG_W;
   localparam int BX_W = NDIG * DIG_W;
   localparam int CNT_W = $clog2(NDIG + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ACC} state_type;

   state_type state_ff;
   logic [ACC_W-1:0] a_ff;
   logic [BX_W-1:0] b_sh_ff;
   logic top_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [ACC_W-1:0] prod_ff;
   logic [ACC_W-1:0] acc_ff;
   logic first_ff;
   logic neg_ff;
   logic done_ff;

   logic signed [BX_W-1:0] b_ext;
   logic signed [DIG_W:0] dig;
   logic signed [ACC_W+DIG_W:0] pp;
   logic [ACC_W-1:0] prod_in;
   logic [ACC_W-1:0] addend;

   assign b_ext = BX_W'(b_op);
   // top digit carries the sign, the rest are unsigned
   assign dig = top_ff ? {b_sh_ff[BX_W-1], b_sh_ff[BX_W-1 -: DIG_W]}
                       : {1'b0, b_sh_ff[BX_W-1 -: DIG_W]};
   assign pp = $signed(a_ff) * dig;
   assign prod_in = (prod_ff << DIG_W) + pp[ACC_W-1:0];
   assign addend = neg_ff ? (~prod_ff + ACC_W'(1)) : prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (state_ff == ST_ACC);
         unique case (state_ff)
            ST_IDLE: begin
               if (ctl.start) begin
                  a_ff <= a_op;
                  b_sh_ff <= b_ext;
                  top_ff <= 1'b1;
                  cnt_ff <= CNT_W'(NDIG - 1);
                  prod_ff <= '0;
                  first_ff <= ctl.first;
                  neg_ff <= ctl.neg;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff <= prod_in;
               b_sh_ff <= b_sh_ff << DIG_W;
               top_ff <= 1'b0;
               if (cnt_ff == '0) begin
                  state_ff <= ST_ACC;
               end else begin
                  cnt_ff <= cnt_ff - CNT_W'(1);
               end
            end
            ST_ACC: begin
               acc_ff <= first_ff ? addend : (acc_ff + addend);
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign acc = acc_ff;
   assign busy = (state_ff != ST_IDLE);
   assign done = done_ff;

endmodule

// File: src/rtnh_div.sv
// radix-2 restoring divider with a saturation check on the quotient range
module rtnh_div import rtnh_pkg::*; #(
   parameter int DIV_W = 146,
   parameter int QUO_W = DIST_W
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [DIV_W-1:0] num,
   input  logic [DIV_W-1:0] den,
   output logic [QUO_W-1:0] quo,
   output logic sat,
   output logic rem_nz,
   output logic done
);
   localparam int CNT_W = $clog2(QUO_W);

   typedef enum logic [1:0] {ST_IDLE, ST_SAT, ST_RUN} state_type;

   state_type state_ff;
   logic [DIV_W-1:0] r_ff;
   logic [DIV_W-1:0] d_ff;
   logic [QUO_W-1:0] q_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic sat_ff;
   logic done_ff;
   logic ge;

   assign ge = (r_ff >= d_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= ((state_ff == ST_SAT) && ge) ||
                    ((state_ff == ST_RUN) && (cnt_ff == '0));
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  r_ff <= num;
                  d_ff <= den << QUO_W;
                  q_ff <= '0;
                  state_ff <= ST_SAT;
               end
            end
            ST_SAT: begin
               if (ge) begin
                  sat_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end else begin
                  sat_ff <= 1'b0;
                  d_ff <= d_ff >> 1;
                  cnt_ff <= CNT_W'(QUO_W - 1);
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (ge) begin
                  r_ff <= r_ff - d_ff;
               end
               q_ff <= {q_ff[QUO_W-2:0], ge};
               d_ff <= d_ff >> 1;
               if (cnt_ff == '0) begin
                  state_ff <= ST_IDLE;
               end else begin
                  cnt_ff <= cnt_ff - CNT_W'(1);
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign quo = q_ff;
   assign sat = sat_ff;
   assign rem_nz = |r_ff;
   assign done = done_ff;

endmodule

// File: src/ray_triangle_nearest_hit_core.sv
// nearest-hit ray versus triangle stream core: sequencer, operand store and hit tracking
// sequence: the 24 product terms run one after another on the shared multiplier, then the
//   checks, division, update and finish; a triangle rejected by the checks skips the division
// a new triangle is accepted only once the previous one is finished; a waiting result beat
//   stalls the finish step
// reset: synchronous, clears the hit record and the result beat; ray registers return
//   to origin zero, direction +z, threshold about 1e-6 and minimum distance zero
module ray_triangle_nearest_hit_core import rtnh_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   rtnh_req_if.sink req_chan,
   rtnh_rsp_if.source rsp_chan,
   input  logic csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata
);
   // edges and offsets need one extra bit, exact products up to 3W+4 bits plus two bits of sum growth
   localparam int NW = COORD_WIDTH + 1;
   localparam int WW = 3 * COORD_WIDTH + 6;
   localparam int CW = (WW > THR_W) ? WW : THR_W;
   localparam int DW = 3 * COORD_WIDTH + FRAC_BITS + 34;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ISSUE, ST_WAIT, ST_NORM, ST_CHK_DET, ST_CHK_U, ST_CHK_V,
      ST_DIV_GO, ST_DIV_WAIT, ST_UPDATE, ST_FINISH
   } state_type;

   // ray registers
   logic signed [COORD_WIDTH-1:0] org_x_ff, org_y_ff, org_z_ff;
   logic signed [COORD_WIDTH-1:0] dir_x_ff, dir_y_ff, dir_z_ff;
   logic [THR_W-1:0] det_thr_ff;
   logic [DIST_W-1:0] min_dist_ff;

   // per-triangle operands
   logic signed [NW-1:0] e1x_ff, e1y_ff, e1z_ff;
   logic signed [NW-1:0] e2x_ff, e2y_ff, e2z_ff;
   logic signed [NW-1:0] sx_ff, sy_ff, sz_ff;
   logic [WW-1:0] h0_ff, h1_ff, h2_ff, q0_ff, q1_ff, q2_ff;
   logic [WW-1:0] det_ff, un_ff, vn_ff, tn_ff;
   logic last_ff;

   state_type state_ff;
   logic [TERM_IDX_W-1:0] term_ff;
   logic have_hit_ff;
   logic [DIST_W-1:0] nearest_ff;
   logic rsp_valid_ff;
   logic rsp_hit_ff;
   logic [DIST_W-1:0] rsp_dist_ff;

   term_type term;
   mac_ctl_type mac_ctl;
   logic [WW-1:0] a_sel;
   logic signed [NW-1:0] b_sel;
   logic [WW-1:0] mac_acc;
   logic mac_busy, mac_done;
   logic div_start;
   logic [DIST_W-1:0] div_quo;
   logic div_sat, div_rem_nz, div_done;
   logic req_beat;
   logic [WW:0] uv_sum;
   logic [DIST_W-1:0] cand_dist;
   logic pass;

   assign term = get_term(term_ff);
   assign req_beat = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // multiplicand: any operand, sign extended to the accumulator width
   always_comb begin
      case (term.a_src)
         OP_D0: a_sel = WW'(dir_x_ff);
         OP_D1: a_sel = WW'(dir_y_ff);
         OP_D2: a_sel = WW'(dir_z_ff);
         OP_E1_0: a_sel = WW'(e1x_ff);
         OP_E1_1: a_sel = WW'(e1y_ff);
         OP_E1_2: a_sel = WW'(e1z_ff);
         OP_E2_0: a_sel = WW'(e2x_ff);
         OP_E2_1: a_sel = WW'(e2y_ff);
         OP_E2_2: a_sel = WW'(e2z_ff);
         OP_S0: a_sel = WW'(sx_ff);
         OP_S1: a_sel = WW'(sy_ff);
         OP_S2: a_sel = WW'(sz_ff);
         OP_H0: a_sel = h0_ff;
         OP_H1: a_sel = h1_ff;
         OP_H2: a_sel = h2_ff;
         OP_Q0: a_sel = q0_ff;
         OP_Q1: a_sel = q1_ff;
         OP_Q2: a_sel = q2_ff;
         default: a_sel = '0;
      endcase
   end

   // multiplier: always a narrow vector component
   always_comb begin
      case (term.b_src)
         OP_D0: b_sel = NW'(dir_x_ff);
         OP_D1: b_sel = NW'(dir_y_ff);
         OP_D2: b_sel = NW'(dir_z_ff);
         OP_E1_0: b_sel = e1x_ff;
         OP_E1_1: b_sel = e1y_ff;
         OP_E1_2: b_sel = e1z_ff;
         OP_E2_0: b_sel = e2x_ff;
         OP_E2_1: b_sel = e2y_ff;
         OP_E2_2: b_sel = e2z_ff;
         OP_S0: b_sel = sx_ff;
         OP_S1: b_sel = sy_ff;
         OP_S2: b_sel = sz_ff;
         default: b_sel = '0;
      endcase
   end

   assign mac_ctl.start = (state_ff == ST_ISSUE);
   assign mac_ctl.first = term.first;
   assign mac_ctl.neg = term.neg;

   rtnh_mac #(
      .ACC_W(WW),
      .B_W(NW)
   ) u_mac (
      .clock(clock),
      .reset(reset),
      .ctl(mac_ctl),
      .a_op(a_sel),
      .b_op(b_sel),
      .acc(mac_acc),
      .busy(mac_busy),
      .done(mac_done)
   );

   // distance = floor(tn * 2^frac / det), det and tn positive here
   assign div_start = (state_ff == ST_DIV_GO);

   rtnh_div #(
      .DIV_W(DW),
      .QUO_W(DIST_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(DW'(tn_ff) << FRAC_BITS),
      .den(DW'(det_ff)),
      .quo(div_quo),
      .sat(div_sat),
      .rem_nz(div_rem_nz),
      .done(div_done)
   );

   assign uv_sum = {1'b0, un_ff} + {1'b0, vn_ff};

   // exact test t > min_distance from the quotient and remainder
   assign cand_dist = div_sat ? DIST_MAX : div_quo;
   assign pass = div_sat || (div_quo > min_dist_ff) ||
                 ((div_quo == min_dist_ff) && div_rem_nz);

   // ray configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff <= '0;
         org_y_ff <= '0;
         org_z_ff <= '0;
         dir_x_ff <= '0;
         dir_y_ff <= '0;
         dir_z_ff <= COORD_WIDTH'(1) << FRAC_BITS;
         det_thr_ff <= DET_THR_RESET;
         min_dist_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_ORIGIN_X: org_x_ff <= csr_wdata[COORD_WIDTH-1:0];
            CSR_ORIGIN_Y: org_y_ff <= csr_wdata[COORD_WIDTH-1:0];
            CSR_ORIGIN_Z: org_z_ff <= csr_wdata[COORD_WIDTH-1:0];
            CSR_DIR_X: dir_x_ff <= csr_wdata[COORD_WIDTH-1:0];
            CSR_DIR_Y: dir_y_ff <= csr_wdata[COORD_WIDTH-1:0];
            CSR_DIR_Z: dir_z_ff <= csr_wdata[COORD_WIDTH-1:0];
            CSR_DET_THR: det_thr_ff <= csr_wdata[THR_W-1:0];
            CSR_MIN_DIST: min_dist_ff <= csr_wdata[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         term_ff <= '0;
         have_hit_ff <= 1'b0;
         nearest_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the finish step of a last triangle drives the flag itself
         if (rsp_valid_ff && rsp_chan.ready && !(state_ff == ST_FINISH && last_ff)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_beat) begin
                  e1x_ff <= NW'(req_chan.b_x) - NW'(req_chan.a_x);
                  e1y_ff <= NW'(req_chan.b_y) - NW'(req_chan.a_y);
                  e1z_ff <= NW'(req_chan.b_z) - NW'(req_chan.a_z);
                  e2x_ff <= NW'(req_chan.c_x) - NW'(req_chan.a_x);
                  e2y_ff <= NW'(req_chan.c_y) - NW'(req_chan.a_y);
                  e2z_ff <= NW'(req_chan.c_z) - NW'(req_chan.a_z);
                  sx_ff <= NW'(org_x_ff) - NW'(req_chan.a_x);
                  sy_ff <= NW'(org_y_ff) - NW'(req_chan.a_y);
                  sz_ff <= NW'(org_z_ff) - NW'(req_chan.a_z);
                  last_ff <= req_chan.last_triangle;
                  term_ff <= '0;
                  state_ff <= ST_ISSUE;
               end
            end
            ST_ISSUE: state_ff <= ST_WAIT;
            ST_WAIT: begin
               if (mac_done) begin
                  if (term.last) begin
                     unique case (term.dst)
                        DST_H0: h0_ff <= mac_acc;
                        DST_H1: h1_ff <= mac_acc;
                        DST_H2: h2_ff <= mac_acc;
                        DST_Q0: q0_ff <= mac_acc;
                        DST_Q1: q1_ff <= mac_acc;
                        DST_Q2: q2_ff <= mac_acc;
                        DST_DET: det_ff <= mac_acc;
                        DST_UN: un_ff <= mac_acc;
                        DST_VN: vn_ff <= mac_acc;
                        DST_TN: tn_ff <= mac_acc;
                        default: ;
                     endcase
                  end
                  if (term_ff == TERM_IDX_W'(NUM_TERMS - 1)) begin
                     state_ff <= ST_NORM;
                  end else begin
                     term_ff <= term_ff + TERM_IDX_W'(1);
                     state_ff <= ST_ISSUE;
                  end
               end
            end
            // double sided: flip everything when the determinant is negative
            ST_NORM: begin
               if (det_ff[WW-1]) begin
                  det_ff <= ~det_ff + WW'(1);
                  un_ff <= ~un_ff + WW'(1);
                  vn_ff <= ~vn_ff + WW'(1);
                  tn_ff <= ~tn_ff + WW'(1);
               end
               state_ff <= ST_CHK_DET;
            end
            ST_CHK_DET: begin
               if ((det_ff == '0) || (CW'(det_ff) < CW'(det_thr_ff))) begin
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_CHK_U;
               end
            end
            ST_CHK_U: begin
               if (un_ff[WW-1] || (un_ff > det_ff)) begin
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_CHK_V;
               end
            end
            // a non-positive t numerator can never beat the minimum distance
            ST_CHK_V: begin
               if (vn_ff[WW-1] || (uv_sum > {1'b0, det_ff}) ||
                   tn_ff[WW-1] || (tn_ff == '0)) begin
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_DIV_GO;
               end
            end
            ST_DIV_GO: state_ff <= ST_DIV_WAIT;
            ST_DIV_WAIT: begin
               if (div_done) begin
                  state_ff <= ST_UPDATE;
               end
            end
            // strict less keeps the first of equal hits
            ST_UPDATE: begin
               if (pass && (!have_hit_ff || (cand_dist < nearest_ff))) begin
                  have_hit_ff <= 1'b1;
                  nearest_ff <= cand_dist;
               end
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (!last_ff) begin
                  state_ff <= ST_IDLE;
               end else if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_hit_ff <= have_hit_ff;
                  rsp_dist_ff <= have_hit_ff ? nearest_ff : '0;
                  have_hit_ff <= 1'b0;
                  nearest_ff <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.hit = rsp_hit_ff;
   assign rsp_chan.distance = rsp_dist_ff;

   // the shared multiplier is only started once the previous term is done
   a_mac_free: assert property (@(posedge clock) disable iff (reset)
      mac_ctl.start |-> !mac_busy)
      else $error("multiplier started while busy");

   // a result beat only comes out of the finish step of a last triangle
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH && last_ff))
      else $error("result beat without a last triangle");

   // no recorded hit means a cleared distance
   a_hit_clear: assert property (@(posedge clock) disable iff (reset)
      !have_hit_ff |-> (nearest_ff == '0))
      else $error("stale nearest distance");

   // the determinant is non-negative once normalized
   a_det_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHK_DET) |-> !det_ff[WW-1])
      else $error("determinant not normalized");

endmodule

// File: test/ray_triangle_nearest_hit_core_tb.sv
// self-checking testbench: a nearest-hit predictor is checked against every result beat
module ray_triangle_nearest_hit_core_tb;
   import rtnh_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 400;    // longer than one triangle takes
   localparam int HOLD_CYCLES = 1500;    // long receiver hold-off
   localparam logic signed [31:0] ONE = 32'sd65536;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic signed [31:0] v[9];   // a xyz, b xyz, c xyz
      logic last;
   } tri_type;

   typedef struct {
      logic hit;
      logic [DIST_W-1:0] distance;
   } hit_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   rtnh_req_if req_chan();
   rtnh_rsp_if rsp_chan();

   ray_triangle_nearest_hit_core dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of the ray setup and the running nearest hit
   logic signed [31:0] ray_org[3];
   logic signed [31:0] ray_dir[3];
   logic [THR_W-1:0] det_thr;
   logic [DIST_W-1:0] min_dist;
   logic seen_hit;
   logic [DIST_W-1:0] best_dist;

   hit_type hit_q[$];
   int errors = 0;
   bit hold_req = 1'b0;
   bit calm = 1'b0;        // no idling on either side while set
   bit first_beat = 1'b1;

   // exact moller-trumbore on wide integers, result pushed on a last triangle
   function automatic void trace_triangle(tri_type t);
      wide_type d[3], e1[3], e2[3], s[3], h[3], q[3];
      wide_type av, det, un, vn, tn, num, lim, qt, thr_w, min_w;
      logic [DIST_W-1:0] hit_dist;
      hit_type r;
      bit ok;
      for (int i = 0; i < 3; i++) begin
         av = t.v[i];
         d[i] = ray_dir[i];
         e1[i] = t.v[3+i];
         e1[i] = e1[i] - av;
         e2[i] = t.v[6+i];
         e2[i] = e2[i] - av;
         s[i] = ray_org[i];
         s[i] = s[i] - av;
      end
      h[0] = d[1]*e2[2] - d[2]*e2[1];
      h[1] = d[2]*e2[0] - d[0]*e2[2];
      h[2] = d[0]*e2[1] - d[1]*e2[0];
      q[0] = s[1]*e1[2] - s[2]*e1[1];
      q[1] = s[2]*e1[0] - s[0]*e1[2];
      q[2] = s[0]*e1[1] - s[1]*e1[0];
      det = e1[0]*h[0] + e1[1]*h[1] + e1[2]*h[2];
      un = s[0]*h[0] + s[1]*h[1] + s[2]*h[2];
      vn = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
      tn = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
      // double sided: flip everything on a negative determinant
      if (det < 0) begin
         det = -det; un = -un; vn = -vn; tn = -tn;
      end
      thr_w = {193'd0, det_thr};
      min_w = {225'd0, min_dist};
      ok = (det != 0) && (det >= thr_w);
      if (ok && (un < 0 || un > det)) ok = 0;
      if (ok && (vn < 0 || un + vn > det)) ok = 0;
      if (ok) begin
         num = tn * 65536;
         lim = min_w * det;
         if (num > lim) begin
            qt = num / det;
            hit_dist = (qt > wide_type'({225'd0, DIST_MAX})) ? DIST_MAX : qt[DIST_W-1:0];
            if (!seen_hit || hit_dist < best_dist) begin
               seen_hit = 1'b1;
               best_dist = hit_dist;
            end
         end
      end
      if (t.last) begin
         r.hit = seen_hit;
         r.distance = seen_hit ? best_dist : '0;
         hit_q.push_back(r);
         seen_hit = 1'b0;
         best_dist = '0;
      end
   endfunction

   function automatic int idle_draw();
      if (calm) return 0;
      return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
   endfunction

   // one triangle beat; valid stays high across back-to-back beats
   task automatic send_tri(tri_type t);
      int gap;
      gap = first_beat ? 0 : idle_draw();
      first_beat = 1'b0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.a_x <= t.v[0]; req_chan.a_y <= t.v[1]; req_chan.a_z <= t.v[2];
      req_chan.b_x <= t.v[3]; req_chan.b_y <= t.v[4]; req_chan.b_z <= t.v[5];
      req_chan.c_x <= t.v[6]; req_chan.c_y <= t.v[7]; req_chan.c_z <= t.v[8];
      req_chan.last_triangle <= t.last;
      do @(posedge clock); while (!req_chan.ready);
      trace_triangle(t);
   endtask

   // register write; caller drops csr_we after the batch
   task automatic csr_write(csr_idx_type idx, logic [CSR_DW-1:0] val);
      logic [CSR_DW-1:0] data;
      data = val;
      if (idx != CSR_DET_THR)
         data[CSR_DW-1:32] = 31'($urandom);   // junk above the register width
      if (idx == CSR_MIN_DIST) data[31] = 1'($urandom_range(0, 1));
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_ORIGIN_X: ray_org[0] = data[31:0];
         CSR_ORIGIN_Y: ray_org[1] = data[31:0];
         CSR_ORIGIN_Z: ray_org[2] = data[31:0];
         CSR_DIR_X: ray_dir[0] = data[31:0];
         CSR_DIR_Y: ray_dir[1] = data[31:0];
         CSR_DIR_Z: ray_dir[2] = data[31:0];
         CSR_DET_THR: det_thr = data[THR_W-1:0];
         CSR_MIN_DIST: min_dist = data[DIST_W-1:0];
         default: ;
      endcase
   endtask

   // stop sending, let the last result come back and the core go idle
   task automatic settle();
      req_chan.valid <= 1'b0;
      first_beat = 1'b1;
      while (hit_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_ray(logic signed [31:0] o[3], logic signed [31:0] d[3],
                          logic [THR_W-1:0] thr, logic [DIST_W-1:0] mind);
      csr_write(CSR_ORIGIN_X, {31'd0, o[0]});
      csr_write(CSR_ORIGIN_Y, {31'd0, o[1]});
      csr_write(CSR_ORIGIN_Z, {31'd0, o[2]});
      csr_write(CSR_DIR_X, {31'd0, d[0]});
      csr_write(CSR_DIR_Y, {31'd0, d[1]});
      csr_write(CSR_DIR_Z, {31'd0, d[2]});
      csr_write(CSR_DET_THR, thr);
      csr_write(CSR_MIN_DIST, {32'd0, mind});
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // triangle in a z plane around the z axis; flip reverses the winding
   function automatic tri_type flat_tri(logic signed [31:0] z, bit flip, logic last);
      tri_type t;
      logic signed [31:0] r;
      r = ONE;
      t.v = '{-r, -r, z, 3*r, -r, z, -r, 3*r, z};
      if (flip) begin
         t.v[3] = -r; t.v[4] = 3*r; t.v[6] = 3*r; t.v[7] = -r;
      end
      t.last = last;
      return t;
   endfunction

   function automatic tri_type noise_tri();
      tri_type t;
      for (int i = 0; i < 9; i++) t.v[i] = $urandom;
      t.last = ($urandom_range(0, 7) == 0);
      return t;
   endfunction

   // triangle around a point on the ray, spread across the two minor axes
   function automatic tri_type aimed_tri();
      tri_type t;
      wide_type c, dw;
      int ax, p1, p2;
      logic signed [31:0] r, cen[3];
      logic [31:0] k;
      ax = 0;
      for (int i = 1; i < 3; i++)
         if ((ray_dir[i] < 0 ? -ray_dir[i] : ray_dir[i]) >
             (ray_dir[ax] < 0 ? -ray_dir[ax] : ray_dir[ax])) ax = i;
      p1 = (ax + 1) % 3;
      p2 = (ax + 2) % 3;
      k = $urandom_range(0, 64 * 65536);
      for (int i = 0; i < 3; i++) begin
         dw = ray_dir[i];
         c = ray_org[i];
         c = c + ((dw * $signed({1'b0, k})) >>> 16);
         cen[i] = c[31:0];
      end
      r = $urandom_range(1, 1 << $urandom_range(4, 24));
      for (int j = 0; j < 3; j++)
         t.v[3*j+ax] = cen[ax] + $signed($urandom_range(0, 8191)) - 4096;
      t.v[p1] = cen[p1] - r;       t.v[p2] = cen[p2] - r;
      t.v[3+p1] = cen[p1] + 3*r;   t.v[3+p2] = cen[p2] - r;
      t.v[6+p1] = cen[p1] - r;     t.v[6+p2] = cen[p2] + 3*r;
      if ($urandom_range(0, 1)) begin
         for (int i = 0; i < 3; i++) begin
            r = t.v[3+i]; t.v[3+i] = t.v[6+i]; t.v[6+i] = r;
         end
      end
      case ($urandom_range(0, 9))
         0: for (int i = 0; i < 3; i++) t.v[3+i] = t.v[i];                 // zero area
         1: for (int i = 0; i < 3; i++) t.v[6+i] = 2*t.v[3+i] - t.v[i];    // collinear
         2: t.v[$urandom_range(0, 8)] = $urandom;                          // broken
         default: ;
      endcase
      t.last = ($urandom_range(0, 6) == 0);
      return t;
   endfunction

   task automatic random_items(int n);
      for (int i = 0; i < n; i++)
         send_tri(($urandom_range(0, 4) == 0) ? noise_tri() : aimed_tri());
      send_tri(flat_tri(ONE, 0, 1'b1));
   endtask

   // reset ray, fixed triangles covering each special case
   task automatic test_directed();
      tri_type t;
      logic signed [31:0] o[3], d[3];
      send_tri(flat_tri(3*ONE, 0, 1'b1));            // plain hit
      t = flat_tri(2*ONE, 0, 1'b1);
      for (int i = 3; i < 9; i++) t.v[i] = t.v[i % 3];
      send_tri(t);                                   // zero determinant
      send_tri(flat_tri(2*ONE, 1, 1'b1));            // negative determinant
      send_tri(flat_tri(0, 0, 1'b1));                // distance zero, not above minimum
      send_tri(flat_tri(1, 0, 1'b1));                // tiny distance
      send_tri(flat_tri(4*ONE, 0, 1'b0));            // equal distances
      send_tri(flat_tri(4*ONE, 1, 1'b0));
      send_tri(flat_tri(-3*ONE, 0, 1'b1));           // behind the origin
      send_tri(flat_tri(9*ONE, 0, 1'b0));            // nearer one wins
      send_tri(flat_tri(6*ONE, 0, 1'b0));
      send_tri(flat_tri(7*ONE, 0, 1'b1));
      for (int i = 0; i < 9; i++) t.v[i] = 32'sh7fffffff;
      t.last = 1'b0;
      send_tri(t);
      for (int i = 0; i < 9; i++) t.v[i] = 32'sh80000000;
      send_tri(t);
      for (int i = 0; i < 9; i++) t.v[i] = (i % 2) ? 32'sh80000000 : 32'sh7fffffff;
      t.last = 1'b1;
      send_tri(t);
      settle();
      // minimum distance 5.0: exactly at it misses, one step past it hits
      o = '{0, 0, 0};
      d = '{0, 0, ONE};
      set_ray(o, d, DET_THR_RESET, DIST_W'(5 * 65536));
      send_tri(flat_tri(5*ONE, 0, 1'b1));
      send_tri(flat_tri(5*ONE + 1, 0, 1'b1));
      settle();
      // tiny direction: far plane saturates the distance
      d = '{0, 0, 1};
      set_ray(o, d, '0, '0);
      send_tri(flat_tri(100*ONE, 0, 1'b1));
      send_tri(flat_tri(-ONE, 1, 1'b1));
      settle();
   endtask

   // random ray setups, extremes among them, random triangles for each
   task automatic test_config_sweep();
      logic signed [31:0] o[3], d[3];
      logic [THR_W-1:0] thr;
      logic [DIST_W-1:0] mind;
      for (int ph = 0; ph < 9; ph++) begin
         calm = (ph == 3);
         for (int i = 0; i < 3; i++) begin
            o[i] = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
            d[i] = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
         end
         d[$urandom_range(0, 2)] = ($urandom_range(0, 1) ? 1 : -1) *
                                   $signed($urandom_range(1 << 12, 1 << 20));
         thr = ($urandom_range(0, 1)) ? DET_THR_RESET : THR_W'($urandom_range(0, 1 << 20));
         mind = ($urandom_range(0, 1)) ? '0 : DIST_W'($urandom_range(0, 8 * 65536));
         case (ph)
            5: begin o = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}; thr = '0; end
            6: begin o = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
                     d = '{0, 32'sh80000000, 0}; mind = '0; end
            7: begin d = '{32'sh7fffffff, 1, -1}; mind = DIST_MAX; end
            8: thr = {THR_W{1'b1}};
            default: ;
         endcase
         set_ray(o, d, thr, mind);
         random_items(ph >= 5 ? 60 : 280);
         settle();
      end
      calm = 1'b0;
   endtask

   // receiver holds off while triangles keep coming, so the core backs up
   task automatic test_backpressure();
      logic signed [31:0] o[3], d[3];
      o = '{0, 0, -ONE};
      d = '{0, 0, ONE};
      set_ray(o, d, DET_THR_RESET, '0);
      hold_req = 1'b1;
      for (int i = 0; i < 40; i++) send_tri(flat_tri((i + 1) * ONE, i % 2, i % 3 == 0));
      random_items(200);
      settle();
   endtask

   // result checker with random stalls and one long hold-off on request
   initial begin
      int stall;
      hit_type exp_hit;
      rsp_chan.ready = 1'b0;
      wait (!reset);
      forever begin
         stall = hold_req ? HOLD_CYCLES : idle_draw();
         hold_req = 1'b0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         if (hit_q.size() == 0) begin
            $display("%0t unexpected beat: hit %0d distance %0d", $time,
                     rsp_chan.hit, rsp_chan.distance);
            errors++;
         end else begin
            exp_hit = hit_q.pop_front();
            if (rsp_chan.hit !== exp_hit.hit) begin
               $display("%0t hit: expected %0d actual %0d", $time, exp_hit.hit, rsp_chan.hit);
               errors++;
            end
            if (rsp_chan.distance !== exp_hit.distance) begin
               $display("%0t distance: expected %0d actual %0d", $time,
                        exp_hit.distance, rsp_chan.distance);
               errors++;
            end
         end
      end
   end

   // watchdog: cycles with no beat on either channel
   int quiet = 0;
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet > WATCHDOG_LIMIT) begin
         $display("ray_triangle_nearest_hit_core: mismatch");
         $finish;
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.a_x = '0; req_chan.a_y = '0; req_chan.a_z = '0;
      req_chan.b_x = '0; req_chan.b_y = '0; req_chan.b_z = '0;
      req_chan.c_x = '0; req_chan.c_y = '0; req_chan.c_z = '0;
      req_chan.last_triangle = 1'b0;
      ray_org = '{0, 0, 0};
      ray_dir = '{0, 0, ONE};
      det_thr = DET_THR_RESET;
      min_dist = '0;
      seen_hit = 1'b0;
      best_dist = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_sweep();
      test_backpressure();
      while (hit_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("ray_triangle_nearest_hit_core: match");
      else
         $display("ray_triangle_nearest_hit_core: mismatch");
      $finish;
   end

endmodule
